// ----- rtl/mbfr_pkg.sv -----
`timescale 1ns / 1ps
package mbfr_pkg;

  localparam int STORE_BITS     = 64;
  localparam int MAX_FIELD_BITS = 32;
  localparam int HELD_W         = $clog2(STORE_BITS + 1);

  localparam int REQ_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 6;
  localparam int FIELD_W  = 32;
  localparam int FIDX_W   = $clog2(FIELD_W);
  localparam int STATUS_W = 2;
  localparam int LEFT_W   = 7;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ALIGN = 2'd2;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_ALIGN = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [BYTE_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               sext;
  } cmd_t;

  function automatic logic [STORE_BITS-1:0] low_mask(input logic [HELD_W-1:0] k);
    logic [STORE_BITS-1:0] m;
    for (int i = 0; i < STORE_BITS; i++) begin
      m[i] = (HELD_W'(i) < k);
    end
    return m;
  endfunction

endpackage

// ----- rtl/mbfr_front.sv -----
`timescale 1ns / 1ps
module mbfr_front (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mbfr_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [mbfr_pkg::REQ_W-1:0]       in_tuser,
  input  logic                             q_full,
  output logic                             q_push,
  output mbfr_pkg::cmd_t                   q_cmd
);

  logic [mbfr_pkg::BYTE_W-1:0]  byte_in;
  logic [mbfr_pkg::COUNT_W-1:0] bit_count;
  logic                         sign_extend;

  assign byte_in     = in_tdata[mbfr_pkg::BYTE_W-1:0];
  assign bit_count   = in_tdata[mbfr_pkg::BYTE_W +: mbfr_pkg::COUNT_W];
  assign sign_extend = in_tdata[mbfr_pkg::BYTE_W + mbfr_pkg::COUNT_W];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_cmd.data = byte_in;
    q_cmd.sext = sign_extend;
    if (bit_count > mbfr_pkg::COUNT_W'(mbfr_pkg::MAX_FIELD_BITS)) begin
      q_cmd.count = mbfr_pkg::COUNT_W'(mbfr_pkg::MAX_FIELD_BITS);
    end else begin
      q_cmd.count = bit_count;
    end
    case (in_tuser)
      mbfr_pkg::REQ_PUSH:  q_cmd.op = mbfr_pkg::OP_PUSH;
      mbfr_pkg::REQ_READ:  q_cmd.op = mbfr_pkg::OP_READ;
      mbfr_pkg::REQ_ALIGN: q_cmd.op = mbfr_pkg::OP_ALIGN;
      default:             q_cmd.op = mbfr_pkg::OP_NOP;
    endcase
  end

endmodule

// ----- rtl/mbfr_queue.sv -----
`timescale 1ns / 1ps
module mbfr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mbfr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mbfr_pkg::cmd_t head_cmd
);

  mbfr_pkg::cmd_t                  slot_r [mbfr_pkg::QUEUE_DEPTH];
  logic [mbfr_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mbfr_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mbfr_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                            do_push, do_pop;

  assign full       = (count_r == mbfr_pkg::QCNT_W'(mbfr_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/mbfr_back.sv -----
`timescale 1ns / 1ps
module mbfr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              head_valid,
  input  mbfr_pkg::cmd_t                    head_cmd,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mbfr_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic [mbfr_pkg::STORE_BITS-1:0] store_r, store_nxt;
  logic [mbfr_pkg::HELD_W-1:0]     held_r, held_nxt;
  logic                            out_valid_r;
  logic [mbfr_pkg::FIELD_W-1:0]    value_r, value_nxt;
  logic [mbfr_pkg::STATUS_W-1:0]   status_r, status_nxt;

  logic [mbfr_pkg::HELD_W-1:0]     n_ext;
  logic [mbfr_pkg::HELD_W-1:0]     rest;
  logic [mbfr_pkg::HELD_W-1:0]     aligned;
  logic [mbfr_pkg::STORE_BITS-1:0] shifted;
  logic [mbfr_pkg::STORE_BITS-1:0] n_mask;
  logic [mbfr_pkg::FIELD_W-1:0]    raw;
  logic [mbfr_pkg::COUNT_W-1:0]    n_m1;
  logic                            sign_bit;

  assign pop = head_valid && (!out_valid_r || out_tready);

  always_comb begin
    n_ext    = mbfr_pkg::HELD_W'(head_cmd.count);
    rest     = held_r - n_ext;
    aligned  = {held_r[mbfr_pkg::HELD_W-1:3], 3'b000};
    shifted  = store_r >> rest;
    n_mask   = mbfr_pkg::low_mask(n_ext);
    raw      = shifted[mbfr_pkg::FIELD_W-1:0] & n_mask[mbfr_pkg::FIELD_W-1:0];
    n_m1     = head_cmd.count - 1'b1;
    sign_bit = raw[n_m1[mbfr_pkg::FIDX_W-1:0]];

    store_nxt  = store_r;
    held_nxt   = held_r;
    value_nxt  = '0;
    status_nxt = mbfr_pkg::ST_OK;
    case (head_cmd.op)
      mbfr_pkg::OP_PUSH: begin
        if (held_r > mbfr_pkg::HELD_W'(mbfr_pkg::STORE_BITS - mbfr_pkg::BYTE_W)) begin
          status_nxt = mbfr_pkg::ST_FULL;
        end else begin
          store_nxt = {store_r[mbfr_pkg::STORE_BITS-mbfr_pkg::BYTE_W-1:0], head_cmd.data};
          held_nxt  = held_r + mbfr_pkg::HELD_W'(mbfr_pkg::BYTE_W);
        end
      end
      mbfr_pkg::OP_READ: begin
        if (n_ext > held_r) begin
          status_nxt = mbfr_pkg::ST_SHORT;
        end else begin
          value_nxt = raw;
          if (head_cmd.sext && (head_cmd.count != '0) && sign_bit) begin
            value_nxt = raw | ~n_mask[mbfr_pkg::FIELD_W-1:0];
          end
          held_nxt  = rest;
          store_nxt = store_r & mbfr_pkg::low_mask(rest);
        end
      end
      mbfr_pkg::OP_ALIGN: begin
        held_nxt  = aligned;
        store_nxt = store_r & mbfr_pkg::low_mask(aligned);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        store_r     <= store_nxt;
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    (mbfr_pkg::OUT_TDATA_W - mbfr_pkg::FIELD_W - mbfr_pkg::STATUS_W - mbfr_pkg::LEFT_W)'(0),
    mbfr_pkg::LEFT_W'(held_r),
    status_r,
    value_r
  };

endmodule

// ----- rtl/msb_first_bit_field_reader_unit.sv -----
`timescale 1ns / 1ps
// channel | ports                      | tdata / tuser fields (lowest bit up)
// in      | in_tvalid in_tready ...    | tuser: req_type[1:0]
//         |                            | tdata: byte_in[7:0] bit_count[13:8] sign_extend[14]
// out     | out_tvalid out_tready ...  | tdata: field_value[31:0] status[33:32]
//         |                            |        bits_left[40:34]
// One transfer per cycle in each direction when neither side stalls; the queue
// stores a request at its input transfer, and the back end pops it from the
// queue head once its output register is free and registers the result there.
// Reset (rst_n low, synchronous) empties the queue and the bit store.
// An output stall holds the result and fills the queue; in_tready drops when
// the queue is full.
module msb_first_bit_field_reader_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mbfr_pkg::IN_TDATA_W-1:0]   in_tdata,   // byte_in, bit_count, sign_extend
  input  logic [mbfr_pkg::REQ_W-1:0]        in_tuser,   // req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mbfr_pkg::OUT_TDATA_W-1:0]  out_tdata   // field_value, status, bits_left
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  mbfr_pkg::cmd_t push_cmd;
  mbfr_pkg::cmd_t head_cmd;

  mbfr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  mbfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  mbfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_full_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[33:32] == mbfr_pkg::ST_FULL) |-> (out_tdata[31:0] == '0))
    else $error("store-full result carries a nonzero field");

  a_short_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[33:32] == mbfr_pkg::ST_SHORT) |-> (out_tdata[31:0] == '0))
    else $error("short read result carries a nonzero field");

  a_left_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[40:34] <= mbfr_pkg::LEFT_W'(mbfr_pkg::STORE_BITS)))
    else $error("bits_left above store size");

  a_pop_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && (!out_tvalid || out_tready))
    else $error("back end took a request without a free output slot");

endmodule
